// File: rtl/oat_pkg.sv
`timescale 1ns / 1ps

package oat_pkg;

  // Field widths of the command and result beats
  localparam int KIND_W      = 2;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int FOUND_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Default table depth
  localparam int DEPTH_DEF = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_NOKEY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SHIFT,
    ST_CMP,
    ST_PUT,
    ST_FIN
  } state_t;

endpackage

// File: rtl/oat_store.sv
`timescale 1ns / 1ps

module oat_store #(
  parameter int DEPTH = oat_pkg::DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IW-1:0]               wr_addr,
  input  logic [oat_pkg::VALUE_W-1:0] wr_data,
  input  logic [IW-1:0]               rd_addr,
  output logic [oat_pkg::VALUE_W-1:0] rd_data
);

  logic [oat_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [oat_pkg::VALUE_W-1:0] rd_data_r;

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/ordered_array_table_core.sv
`timescale 1ns / 1ps

// Positional table of DEPTH signed 32-bit entries with a fill count. Each command beat
// (insert, delete, search or update) gives one result beat carrying status, search
// index and the fill count after the command. The block takes one command at a time
// and walks the entry memory through its one read port and one write port, with a read state
// (ST_RD) and then a write or compare state (ST_SHIFT or ST_CMP) for each entry moved or
// examined; an accepted insert or update ends by writing the new value (ST_PUT). A
// result waiting in the output register holds off the next completion only.

module ordered_array_table_core #(
  parameter int DEPTH = oat_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [oat_pkg::IN_TDATA_W-1:0]  in_tdata,   // kind[1:0], value[33:2], position[37:34]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [oat_pkg::OUT_TDATA_W-1:0] out_tdata   // status[1:0], found_index[5:2], count[10:6]
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > oat_pkg::POS_W) ? CW : oat_pkg::POS_W;

  // Unpack the command beat
  oat_pkg::kind_t               in_kind;
  logic [oat_pkg::VALUE_W-1:0]  in_value;
  logic [oat_pkg::POS_W-1:0]    in_pos;
  logic [KW-1:0]                pos_k;
  logic [KW-1:0]                cnt_k;
  logic                         in_fire;

  oat_pkg::state_t              state_r, state_nxt;
  oat_pkg::kind_t               kind_r, kind_nxt;
  logic [oat_pkg::VALUE_W-1:0]  val_r, val_nxt;
  logic [IW-1:0]                pos_r, pos_nxt;
  logic [IW-1:0]                ptr_r, ptr_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  oat_pkg::status_t             status_r, status_nxt;
  logic [oat_pkg::FOUND_W-1:0]  found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [oat_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  logic [oat_pkg::VALUE_W-1:0]  wr_data;
  logic [IW-1:0]                rd_addr;
  logic [oat_pkg::VALUE_W-1:0]  rd_data;

  assign in_kind  = oat_pkg::kind_t'(in_tdata[1:0]);
  assign in_value = in_tdata[33:2];
  assign in_pos   = in_tdata[37:34];
  assign pos_k    = KW'(in_pos);
  assign cnt_k    = KW'(count_r);
  assign in_fire  = in_tvalid && in_tready;

  oat_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == oat_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oat_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    val_r      <= val_nxt;
    pos_r      <= pos_nxt;
    ptr_r      <= ptr_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rd_data;
    rd_addr       = ptr_r;

    // Retire a taken result beat
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      oat_pkg::ST_IDLE: begin
        if (in_fire) begin
          kind_nxt   = in_kind;
          val_nxt    = in_value;
          pos_nxt    = IW'(in_pos);
          status_nxt = oat_pkg::STAT_OK;
          found_nxt  = '0;
          state_nxt  = oat_pkg::ST_FIN;
          unique case (in_kind)
            oat_pkg::KIND_INSERT: begin
              if (count_r >= CW'(DEPTH)) begin
                status_nxt = oat_pkg::STAT_FULL;
              end else if (pos_k > cnt_k) begin
                status_nxt = oat_pkg::STAT_BADPOS;
              end else if (pos_k == cnt_k) begin
                state_nxt = oat_pkg::ST_PUT;
              end else begin
                ptr_nxt   = IW'(count_r);
                state_nxt = oat_pkg::ST_RD;
              end
            end
            oat_pkg::KIND_DELETE: begin
              if (pos_k >= cnt_k) begin
                status_nxt = oat_pkg::STAT_BADPOS;
              end else if (pos_k + KW'(1) == cnt_k) begin
                count_nxt = count_r - CW'(1);
              end else begin
                ptr_nxt   = IW'(in_pos);
                state_nxt = oat_pkg::ST_RD;
              end
            end
            oat_pkg::KIND_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = oat_pkg::STAT_NOKEY;
              end else begin
                ptr_nxt   = '0;
                state_nxt = oat_pkg::ST_RD;
              end
            end
            oat_pkg::KIND_UPDATE: begin
              if (pos_k >= cnt_k) begin
                status_nxt = oat_pkg::STAT_BADPOS;
              end else begin
                state_nxt = oat_pkg::ST_PUT;
              end
            end
            default: begin
              status_nxt = oat_pkg::STAT_BADPOS;
            end
          endcase
        end
      end

      // Read the source entry of this step
      oat_pkg::ST_RD: begin
        case (kind_r)
          oat_pkg::KIND_INSERT: rd_addr = ptr_r - IW'(1);
          oat_pkg::KIND_DELETE: rd_addr = ptr_r + IW'(1);
          default:              rd_addr = ptr_r;
        endcase
        state_nxt = (kind_r == oat_pkg::KIND_SEARCH) ? oat_pkg::ST_CMP : oat_pkg::ST_SHIFT;
      end

      // Move one entry up or down
      oat_pkg::ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if (kind_r == oat_pkg::KIND_INSERT) begin
          ptr_nxt   = ptr_r - IW'(1);
          state_nxt = (ptr_r - IW'(1) == pos_r) ? oat_pkg::ST_PUT : oat_pkg::ST_RD;
        end else begin
          ptr_nxt = ptr_r + IW'(1);
          if (CW'(ptr_r) + CW'(2) == count_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = oat_pkg::ST_FIN;
          end else begin
            state_nxt = oat_pkg::ST_RD;
          end
        end
      end

      // Compare one entry against the key
      oat_pkg::ST_CMP: begin
        if (rd_data == val_r) begin
          found_nxt = oat_pkg::FOUND_W'(ptr_r);
          state_nxt = oat_pkg::ST_FIN;
        end else if (CW'(ptr_r) + CW'(1) == count_r) begin
          status_nxt = oat_pkg::STAT_NOKEY;
          state_nxt  = oat_pkg::ST_FIN;
        end else begin
          ptr_nxt   = ptr_r + IW'(1);
          state_nxt = oat_pkg::ST_RD;
        end
      end

      // Write the new value into its slot
      oat_pkg::ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = val_r;
        if (kind_r == oat_pkg::KIND_INSERT) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = oat_pkg::ST_FIN;
      end

      // Hand the result to the output register once it is free
      oat_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {(oat_pkg::OUT_TDATA_W - 11)'(0),
                           oat_pkg::COUNT_W'(count_r), found_r, status_r};
          out_valid_nxt = 1'b1;
          state_nxt     = oat_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = oat_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
